@@ rtl/core/sq_cq_ring_doorbell_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// sq_cq_ring_doorbell_tracker_defines.svh
// Assertion macros used by the ring tracker top level.
// ----------------------------------------------------------------------------
`ifndef SQ_CQ_RING_DOORBELL_TRACKER_DEFINES_SVH
`define SQ_CQ_RING_DOORBELL_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SQCQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define SQCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sqcq_pkg.sv @@
// ----------------------------------------------------------------------------
// sqcq_pkg
// Types and constants of the submission/completion ring tracker.
// ----------------------------------------------------------------------------
package sqcq_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int TAG_WIDTH   = 16;
  localparam int IDX_W       = $clog2(RING_DEPTH);

  // Fixed field widths
  localparam int QNUM_W      = 16;
  localparam int CMD_W       = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int RTAG_W      = 16;
  localparam int STATUS_W    = 8;
  localparam int SLOT_W      = 10;
  localparam int DB_IDX_W    = 16;
  localparam int DB_W        = 64;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 96;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 8'h00;
  localparam logic [STATUS_W-1:0] STATUS_OK_ALT = 8'h0d;

  typedef enum logic {
    KIND_SUBMIT = 1'b0,
    KIND_POLL   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RC_OK    = 2'd0,
    RC_BUSY  = 2'd1,
    RC_AGAIN = 2'd2,
    RC_IOERR = 2'd3
  } rc_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_QUEUE_NUMBER = 2'd0,
    CFG_SQ_DB_CMD    = 2'd1,
    CFG_CQ_DB_CMD    = 2'd2
  } cfg_idx_t;

  // Access to the tag cache for one word
  typedef struct packed {
    logic                 we;
    logic                 rd;
    logic [IDX_W-1:0]     addr;
    logic [TAG_WIDTH-1:0] wdata;
  } tag_req_t;

  // Result of one word, minus the tag that comes out of the cache
  typedef struct packed {
    rc_t               rc;
    logic              db_valid;
    logic [DB_W-1:0]   db_word;
    logic [SLOT_W-1:0] slot;
    logic              tag_sel;
  } res_t;

  // Ring state, seen by the checks in the top level
  typedef struct packed {
    logic             full;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] sq_head;
  } ring_stat_t;

endpackage

@@ rtl/core/sq_cq_ring_doorbell_tracker.sv @@
// ----------------------------------------------------------------------------
// sq_cq_ring_doorbell_tracker
// Submission/completion ring pair tracker with phase bit and doorbells.
// ----------------------------------------------------------------------------
//  channel | dir | ports                      | word
//  in      | in  | in_tvalid/tready/tdata/tuser | submit or poll request
//  out     | out | out_tvalid/tready/tdata    | result and doorbell
//  cfg     | in  | cfg_we/addr/wdata          | register write, no read-back
//
// One word per cycle while in_tready is high; its result shows in the cycle after
// acceptance, when the tag cache read (one port, registered) and the result register load.
// Ring state updates at the accepting edge, so the next word sees it.
// in_tready drops only while a result waits and out_tready is low.
// Reset is synchronous; the tag cache is not cleared.
// ----------------------------------------------------------------------------
`include "sq_cq_ring_doorbell_tracker_defines.svh"

module sq_cq_ring_doorbell_tracker
  import sqcq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // request_tag[15:0], completion_phase[16], entry_status[24:17], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // result_code[1:0], doorbell_valid[2], doorbell_word[66:3],
  // slot_index[76:67], response_tag[92:77], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                 acc;
  res_t                 res;
  res_t                 res_r;
  tag_req_t             tag_req;
  ring_stat_t           stat;
  logic [TAG_WIDTH-1:0] tag_rdata;
  logic [RTAG_W-1:0]    rsp_tag;
  logic                 out_valid_r, out_valid_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  sqcq_ring_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .acc              (acc),
    .kind             (kind_t'(in_tuser)),
    .request_tag      (in_tdata[15:0]),
    .completion_phase (in_tdata[16]),
    .entry_status     (in_tdata[24:17]),
    .res              (res),
    .tag_req          (tag_req),
    .stat             (stat)
  );

  sqcq_tag_ram u_tag_ram (
    .clk   (clk),
    .req   (tag_req),
    .rdata (tag_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign rsp_tag    = res_r.tag_sel ? RTAG_W'(tag_rdata) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, rsp_tag, res_r.slot, res_r.db_word, res_r.db_valid, res_r.rc};

  `SQCQ_ASSERT_SAME(a_full_meets_head, stat.full, stat.tail == stat.sq_head,
    "ring full while tail and head differ")
  `SQCQ_ASSERT_SAME(a_db_only_on_ok, out_tvalid,
    res_r.db_valid == (res_r.rc == RC_OK), "doorbell flag disagrees with result code")
  `SQCQ_ASSERT_SAME(a_quiet_on_refusal, out_tvalid && res_r.rc != RC_OK,
    res_r.db_word == '0 && rsp_tag == '0, "refused word carries doorbell or tag")
  `SQCQ_ASSERT_NEXT(a_busy_when_full, acc && in_tuser == KIND_SUBMIT && stat.full,
    out_tvalid && res_r.rc == RC_BUSY, "submit into full ring not refused")

endmodule

@@ rtl/core/sqcq_tag_ram.sv @@
// ----------------------------------------------------------------------------
// sqcq_tag_ram
// Tag cache: one slot per ring entry, one access a cycle, registered read.
// ----------------------------------------------------------------------------
module sqcq_tag_ram
  import sqcq_pkg::*;
(
  input  logic                 clk,
  input  tag_req_t             req,
  output logic [TAG_WIDTH-1:0] rdata
);

  logic [TAG_WIDTH-1:0] mem [RING_DEPTH];
  logic [TAG_WIDTH-1:0] rdata_r;

  // Read returns the old word when the same slot is cleared in this cycle
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/sqcq_ring_ctrl.sv @@
// ----------------------------------------------------------------------------
// sqcq_ring_ctrl
// Ring indices, phase, full flag and config registers; decides each word.
// ----------------------------------------------------------------------------
module sqcq_ring_ctrl
  import sqcq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  acc,
  input  kind_t                 kind,
  input  logic [RTAG_W-1:0]     request_tag,
  input  logic                  completion_phase,
  input  logic [STATUS_W-1:0]   entry_status,
  output res_t                  res,
  output tag_req_t              tag_req,
  output ring_stat_t            stat
);

  logic [QNUM_W-1:0] qnum_r, qnum_nxt;
  logic [CMD_W-1:0]  sq_cmd_r, sq_cmd_nxt;
  logic [CMD_W-1:0]  cq_cmd_r, cq_cmd_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [IDX_W-1:0]  sq_head_r, sq_head_nxt;
  logic [IDX_W-1:0]  cq_head_r, cq_head_nxt;
  logic              phase_r, phase_nxt;
  logic              full_r, full_nxt;
  logic [IDX_W-1:0]  tail_inc, head_inc;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    return r;
  endfunction

  assign tail_inc = next_idx(tail_r);
  assign head_inc = next_idx(cq_head_r);

  always_comb begin
    qnum_nxt   = qnum_r;
    sq_cmd_nxt = sq_cmd_r;
    cq_cmd_nxt = cq_cmd_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_QUEUE_NUMBER: qnum_nxt   = cfg_wdata;
        CFG_SQ_DB_CMD:    sq_cmd_nxt = cfg_wdata[CMD_W-1:0];
        CFG_CQ_DB_CMD:    cq_cmd_nxt = cfg_wdata[CMD_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    tail_nxt     = tail_r;
    sq_head_nxt  = sq_head_r;
    cq_head_nxt  = cq_head_r;
    phase_nxt    = phase_r;
    full_nxt     = full_r;
    res.rc       = RC_OK;
    res.db_valid = 1'b0;
    res.db_word  = '0;
    res.slot     = SLOT_W'(tail_r);
    res.tag_sel  = 1'b0;
    tag_req      = '0;
    tag_req.addr = tail_r;
    if (acc) begin
      if (kind == KIND_SUBMIT) begin
        if (full_r) begin
          res.rc = RC_BUSY;
        end else begin
          tag_req.we    = 1'b1;
          tag_req.wdata = TAG_WIDTH'(request_tag);
          tail_nxt      = tail_inc;
          full_nxt      = (tail_inc == sq_head_r);
          res.db_valid  = 1'b1;
          res.db_word   = {16'h0000, DB_IDX_W'(tail_inc), 8'h00, sq_cmd_r, qnum_r};
        end
      end else begin
        res.slot     = SLOT_W'(cq_head_r);
        tag_req.addr = cq_head_r;
        priority if (completion_phase != phase_r) begin
          res.rc = RC_AGAIN;
        end else if (entry_status != STATUS_OK && entry_status != STATUS_OK_ALT) begin
          res.rc = RC_IOERR;
        end else begin
          // Read the cached tag and clear the slot behind it
          tag_req.rd   = 1'b1;
          tag_req.we   = 1'b1;
          full_nxt     = 1'b0;
          cq_head_nxt  = head_inc;
          sq_head_nxt  = head_inc;
          phase_nxt    = (head_inc == '0) ? ~phase_r : phase_r;
          res.db_valid = 1'b1;
          res.db_word  = {16'h0000, DB_IDX_W'(head_inc), 8'h00, cq_cmd_r, qnum_r};
          res.tag_sel  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qnum_r    <= '0;
      sq_cmd_r  <= '0;
      cq_cmd_r  <= CMD_W'(1);
      tail_r    <= '0;
      sq_head_r <= '0;
      cq_head_r <= '0;
      phase_r   <= 1'b1;
      full_r    <= 1'b0;
    end else begin
      qnum_r    <= qnum_nxt;
      sq_cmd_r  <= sq_cmd_nxt;
      cq_cmd_r  <= cq_cmd_nxt;
      tail_r    <= tail_nxt;
      sq_head_r <= sq_head_nxt;
      cq_head_r <= cq_head_nxt;
      phase_r   <= phase_nxt;
      full_r    <= full_nxt;
    end
  end

  assign stat.full    = full_r;
  assign stat.tail    = tail_r;
  assign stat.sq_head = sq_head_r;

endmodule

@@ dv/tb_sq_cq_ring_doorbell_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_sq_cq_ring_doorbell_tracker
// Self-checking bench for the submission/completion ring tracker. A clocked
// driver feeds submit and poll words from a queue. A shadow copy of the
// ring indices, phase, full flag and tag cache predicts each result at the
// accepting edge. A clocked monitor compares every result word field by
// field. The stimulus runs a directed pass over the special cases, then a
// pass that wraps the tail and fills the ring until it refuses words as
// busy. After that, random phases mix submits with good and broken polls.
// Doorbell settings change between phases, and both sides stall at random.
// ----------------------------------------------------------------------------
module tb_sq_cq_ring_doorbell_tracker;
  import sqcq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SQUEEZE_AT     = 1200;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int RAND_PHASE_LEN = 200;

  typedef struct packed {
    kind_t               kind;
    logic [RTAG_W-1:0]   tag;
    logic                phase;
    logic [STATUS_W-1:0] status;
  } ring_req_t;

  typedef struct packed {
    rc_t               rc;
    logic              db_valid;
    logic [DB_W-1:0]   db_word;
    logic [SLOT_W-1:0] slot;
    logic [RTAG_W-1:0] tag;
  } ring_rsp_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sq_cq_ring_doorbell_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // Shadow of the doorbell registers and ring state
  logic [QNUM_W-1:0]    qnum_reg   = '0;
  logic [CMD_W-1:0]     sq_cmd_reg = '0;
  logic [CMD_W-1:0]     cq_cmd_reg = 8'h01;
  logic [IDX_W-1:0]     sq_tail    = '0;
  logic [IDX_W-1:0]     sq_head    = '0;
  logic [IDX_W-1:0]     cq_head    = '0;
  logic                 cq_phase   = 1'b1;
  logic                 ring_full  = 1'b0;
  logic [TAG_WIDTH-1:0] tag_cache [RING_DEPTH];
  int                   cq_wraps   = 0;

  // Steering copy of the completion head and phase, kept by the generator
  logic [IDX_W-1:0]     plan_cq    = '0;
  logic                 plan_phase = 1'b1;

  ring_req_t pending_words[$];
  ring_rsp_t expected_results[$];
  ring_req_t cur_word;

  int idle_pct     = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  bit squeezed     = 1'b0;
  int results_seen = 0;
  int errors       = 0;
  int stall_cycles = 0;
  int rc_seen [4]  = '{0, 0, 0, 0};

  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [DB_W-1:0] ring_doorbell(input logic [CMD_W-1:0] cmd,
                                                    input logic [IDX_W-1:0] idx);
    // priority, index, reserved byte, command, queue number
    return {16'h0000, DB_IDX_W'(idx), 8'h00, cmd, qnum_reg};
  endfunction

  function automatic ring_rsp_t predict_result(input ring_req_t w);
    ring_rsp_t        r;
    logic [IDX_W-1:0] nxt;
    r = '0;
    if (w.kind == KIND_SUBMIT) begin
      r.slot = SLOT_W'(sq_tail);
      if (ring_full) begin
        r.rc = RC_BUSY;
      end else begin
        tag_cache[sq_tail] = w.tag;
        nxt = step_index(sq_tail);
        sq_tail = nxt;
        if (nxt == sq_head) ring_full = 1'b1;
        r.rc = RC_OK;
        r.db_valid = 1'b1;
        r.db_word = ring_doorbell(sq_cmd_reg, nxt);
      end
    end else begin
      r.slot = SLOT_W'(cq_head);
      if (w.phase != cq_phase) begin
        r.rc = RC_AGAIN;
      end else if (w.status != STATUS_OK && w.status != STATUS_OK_ALT) begin
        r.rc = RC_IOERR;
      end else begin
        ring_full = 1'b0;
        // consume the cached tag
        r.tag = tag_cache[cq_head];
        tag_cache[cq_head] = '0;
        nxt = step_index(cq_head);
        if (nxt == '0) begin
          cq_phase = ~cq_phase;
          cq_wraps++;
        end
        cq_head = nxt;
        sq_head = nxt;
        r.rc = RC_OK;
        r.db_valid = 1'b1;
        r.db_word = ring_doorbell(cq_cmd_reg, nxt);
      end
    end
    return r;
  endfunction

  task automatic queue_submit(input logic [RTAG_W-1:0] tag);
    ring_req_t w;
    w.kind   = KIND_SUBMIT;
    w.tag    = tag;
    w.phase  = 1'($urandom);
    w.status = STATUS_W'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic queue_poll(input logic phase, input logic [STATUS_W-1:0] status);
    ring_req_t w;
    w.kind   = KIND_POLL;
    w.tag    = RTAG_W'($urandom);
    w.phase  = phase;
    w.status = status;
    pending_words.push_back(w);
    if (phase == plan_phase && (status == STATUS_OK || status == STATUS_OK_ALT)) begin
      plan_cq = step_index(plan_cq);
      if (plan_cq == '0) plan_phase = ~plan_phase;
    end
  endtask

  // Mostly well-formed polls and submits, with a tail of broken polls
  task automatic queue_random_words(input int count, input int poll_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll >= poll_pct) begin
        queue_submit(RTAG_W'($urandom));
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 90)
          queue_poll(plan_phase, $urandom_range(1, 0) ? STATUS_OK_ALT : STATUS_OK);
        else if (roll < 95)
          queue_poll(~plan_phase, STATUS_W'($urandom));
        else
          queue_poll(plan_phase, STATUS_W'($urandom));
      end
    end
  endtask

  // Sample between edges so the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  // Write all three registers back to back, then drop cfg_we
  task automatic write_config(input logic [CFG_DATA_W-1:0] qn,
                              input logic [CFG_DATA_W-1:0] sq,
                              input logic [CFG_DATA_W-1:0] cq);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_QUEUE_NUMBER;
    cfg_wdata <= qn;
    qnum_reg  = qn[QNUM_W-1:0];
    @(posedge clk);
    cfg_addr   <= CFG_SQ_DB_CMD;
    cfg_wdata  <= sq;
    sq_cmd_reg = sq[CMD_W-1:0];
    @(posedge clk);
    cfg_addr   <= CFG_CQ_DB_CMD;
    cfg_wdata  <= cq;
    cq_cmd_reg = cq[CMD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: present the next word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_result(cur_word));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'({cur_word.status, cur_word.phase, cur_word.tag});
          in_tuser  <= cur_word.kind;
          if ($urandom_range(99, 0) < idle_pct) gap_left = $urandom_range(7, 1);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word, stall the output at random
  always @(posedge clk) begin
    ring_rsp_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t result word with nothing expected: %h", $time, out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          rc_seen[exp_r.rc]++;
          check_field("result_code", 64'(exp_r.rc), 64'(out_tdata[1:0]));
          check_field("doorbell_valid", 64'(exp_r.db_valid), 64'(out_tdata[2]));
          check_field("doorbell_word", exp_r.db_word, out_tdata[66:3]);
          check_field("slot_index", 64'(exp_r.slot), 64'(out_tdata[76:67]));
          check_field("response_tag", 64'(exp_r.tag), 64'(out_tdata[92:77]));
        end
      end
      // hold off long enough once to back the input up
      if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end else if (hold_left == 0 && $urandom_range(99, 0) < idle_pct) begin
        hold_left = $urandom_range(7, 1);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t watchdog: no handshake for %0d cycles", $time, stall_cycles);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset settings: refusals first, then submit and consume
    idle_pct = 25;
    queue_poll(1'b0, STATUS_OK);
    queue_poll(1'b1, 8'h01);
    queue_poll(1'b1, 8'hff);
    queue_poll(1'b1, 8'h0c);
    queue_poll(1'b1, 8'h0e);
    queue_submit(16'h0000);
    queue_submit(16'hffff);
    queue_submit(16'h8001);
    queue_submit(16'h7ffe);
    queue_poll(1'b1, STATUS_OK);
    queue_poll(1'b1, STATUS_OK_ALT);
    queue_poll(1'b0, STATUS_OK_ALT);
    queue_poll(1'b1, 8'h80);
    queue_poll(1'b1, STATUS_OK);
    queue_submit(RTAG_W'($urandom));
    queue_poll(1'b1, STATUS_OK_ALT);
    queue_poll(1'b1, STATUS_OK);
    wait_idle();

    // Fill every slot until the ring is full, then knock on it while full
    idle_pct = 10;
    write_config(16'hffff, 16'hffff, 16'hff00);
    for (int i = 0; i < RING_DEPTH; i++) queue_submit(RTAG_W'($urandom));
    queue_poll(~plan_phase, STATUS_OK);
    queue_poll(plan_phase, 8'h42);
    for (int i = 0; i < 6; i++) queue_submit(RTAG_W'($urandom));
    wait_idle();

    // Random phases; every cache slot now holds a defined tag
    idle_pct = 25;
    write_config(16'h0000, 16'h5500, 16'h00ff);
    queue_random_words(RAND_PHASE_LEN, 45);
    wait_idle();

    idle_pct = 0;
    write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    queue_random_words(RAND_PHASE_LEN, 85);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("ran %0d words: %0d ok, %0d busy, %0d again, %0d io error",
             results_seen, rc_seen[RC_OK], rc_seen[RC_BUSY], rc_seen[RC_AGAIN],
             rc_seen[RC_IOERR]);
    $display("completion head wrapped %0d time(s); output held off %0d cycles once",
             cq_wraps, SQUEEZE_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sqcq_pkg.sv
rtl/core/sqcq_tag_ram.sv
rtl/core/sqcq_ring_ctrl.sv
rtl/core/sq_cq_ring_doorbell_tracker.sv
dv/tb_sq_cq_ring_doorbell_tracker.sv
